// ===== hdl/bpl_pkg.sv =====
// Shared types and constants for the bouncing pulse LED renderer.
package bpl_pkg;

  localparam int PIXEL_COUNT = 64;
  localparam int RING_SPAN   = PIXEL_COUNT * 256;
  localparam int POS_W       = $clog2(RING_SPAN);
  localparam int SQ_W        = 2 * POS_W;
  localparam int FALL_SHIFT  = 11;
  localparam int FALL_W      = SQ_W - FALL_SHIFT;

  localparam logic [POS_W-1:0] MIRROR_RESET = POS_W'(RING_SPAN / 2);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  localparam logic [7:0] SPAWN_CODE   = 8'hFF;
  localparam logic [1:0] REVERSE_CODE = 2'h3;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_PIXEL = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS   = 3'd0,
    REG_STEP_SIZE    = 3'd1,
    REG_HUE_DIVIDER  = 3'd2,
    REG_HUE_LIMIT    = 3'd3,
    REG_SPLIT_ENABLE = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] brightness;
    logic [7:0] step_size;
    logic [6:0] hue_divider;
    logic [8:0] hue_limit;
    logic       split_enable;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0] main_pos;
    logic [POS_W-1:0] mirror_pos;
    logic             mirror_act;
    logic             backward;
    logic [7:0]       hue;
    logic [6:0]       hue_cnt;
  } anim_state_t;

endpackage

// ===== hdl/bpl_pulse.sv =====
// Level that one pulse contributes to one pixel.
module bpl_pulse (
  input  logic [bpl_pkg::POS_W-1:0] pos,
  input  logic [5:0]                pixel_index,
  input  logic [7:0]                brightness,
  output logic [7:0]                level
);

  logic [bpl_pkg::POS_W-1:0]  pix_pos;
  logic [bpl_pkg::POS_W-1:0]  gap;
  logic [bpl_pkg::POS_W:0]    dist_alt;
  logic [bpl_pkg::POS_W-1:0]  dist_min;
  logic [bpl_pkg::SQ_W-1:0]   sq;
  logic [bpl_pkg::FALL_W-1:0] fall;

  always_comb begin
    pix_pos  = bpl_pkg::POS_W'({pixel_index, 8'h00});
    gap      = (pix_pos >= pos) ? (pix_pos - pos) : (pos - pix_pos);
    // Take the shorter way round the ring.
    dist_alt = (bpl_pkg::POS_W+1)'(bpl_pkg::RING_SPAN) - {1'b0, gap};
    dist_min = ({1'b0, gap} > dist_alt) ? dist_alt[bpl_pkg::POS_W-1:0] : gap;
    sq       = bpl_pkg::SQ_W'(dist_min) * bpl_pkg::SQ_W'(dist_min);
    fall     = sq[bpl_pkg::SQ_W-1:bpl_pkg::FALL_SHIFT];
    if (fall > bpl_pkg::FALL_W'(brightness)) begin
      level = 8'h00;
    end else begin
      level = brightness - fall[7:0];
    end
  end

endmodule

// ===== hdl/bpl_anim.sv =====
// Animation state: hue divider, reflection spawn and removal, pulse motion.
module bpl_anim (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bpl_pkg::cfg_t         cfg,
  input  logic                  tick_en,
  input  logic [7:0]            rnd,
  output bpl_pkg::anim_state_t  st,
  output bpl_pkg::anim_state_t  st_nxt
);

  bpl_pkg::anim_state_t st_r;
  bpl_pkg::anim_state_t tick_st;
  logic [8:0]               hue_inc;
  logic [7:0]               hue_adv;
  logic [bpl_pkg::POS_W-1:0] mv_main;
  logic [bpl_pkg::POS_W-1:0] mv_mirror;

  function automatic logic [bpl_pkg::POS_W-1:0] ring_add(
    input logic [bpl_pkg::POS_W-1:0] p,
    input logic [7:0]                d
  );
    logic [bpl_pkg::POS_W:0] s;
    s = {1'b0, p} + (bpl_pkg::POS_W+1)'(d);
    if (s >= (bpl_pkg::POS_W+1)'(bpl_pkg::RING_SPAN)) begin
      s = s - (bpl_pkg::POS_W+1)'(bpl_pkg::RING_SPAN);
    end
    return s[bpl_pkg::POS_W-1:0];
  endfunction

  function automatic logic [bpl_pkg::POS_W-1:0] ring_sub(
    input logic [bpl_pkg::POS_W-1:0] p,
    input logic [7:0]                d
  );
    logic [bpl_pkg::POS_W:0] s;
    if ({1'b0, p} >= (bpl_pkg::POS_W+1)'(d)) begin
      s = {1'b0, p} - (bpl_pkg::POS_W+1)'(d);
    end else begin
      s = {1'b0, p} + (bpl_pkg::POS_W+1)'(bpl_pkg::RING_SPAN) - (bpl_pkg::POS_W+1)'(d);
    end
    return s[bpl_pkg::POS_W-1:0];
  endfunction

  always_comb begin
    hue_inc = {1'b0, st_r.hue} + 9'd1;
    hue_adv = (hue_inc >= cfg.hue_limit) ? 8'h00 : hue_inc[7:0];
    tick_st = st_r;

    if (cfg.split_enable) begin
      if (st_r.hue_cnt <= 7'd1) begin
        tick_st.hue_cnt = cfg.hue_divider;
        tick_st.hue     = hue_adv;
      end else begin
        tick_st.hue_cnt = st_r.hue_cnt - 7'd1;
      end
      if (!st_r.mirror_act) begin
        if (rnd == bpl_pkg::SPAWN_CODE) begin
          tick_st.mirror_act = 1'b1;
          tick_st.mirror_pos = st_r.main_pos;
        end
      end else if (st_r.main_pos == st_r.mirror_pos) begin
        tick_st.mirror_act = 1'b0;
        if (rnd[1:0] == bpl_pkg::REVERSE_CODE) begin
          tick_st.backward = !st_r.backward;
        end
      end
    end else begin
      tick_st.hue = hue_adv;
    end

    // The mirror always travels opposite to the main pulse.
    if (tick_st.backward) begin
      mv_main   = ring_sub(tick_st.main_pos, cfg.step_size);
      mv_mirror = ring_add(tick_st.mirror_pos, cfg.step_size);
    end else begin
      mv_main   = ring_add(tick_st.main_pos, cfg.step_size);
      mv_mirror = ring_sub(tick_st.mirror_pos, cfg.step_size);
    end
    tick_st.main_pos   = mv_main;
    tick_st.mirror_pos = mv_mirror;

    st_nxt = tick_en ? tick_st : st_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.main_pos   <= '0;
      st_r.mirror_pos <= bpl_pkg::MIRROR_RESET;
      st_r.mirror_act <= 1'b1;
      st_r.backward   <= 1'b0;
      st_r.hue        <= 8'h00;
      st_r.hue_cnt    <= 7'd3;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign st = st_r;

endmodule

// ===== hdl/bouncing_pulse_led_renderer.sv =====
// Two register stages, s1 and the output register; out_valid rises when the item leaves s1.
// Throughput: one item per cycle while out_ready is high; one pass against the animation state.
// Pixel reads use two 14 x 14 squarers in parallel, one per pulse.
// Reset (synchronous, rst_n low) empties both stages, loads the register defaults and
// returns the pulses, hue and divider to their start values.
module bouncing_pulse_led_renderer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_opcode,
  input  logic [5:0]                     in_pixel_index,
  input  logic [7:0]                     in_random_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_pixel_level,
  output logic [7:0]                     out_hue,
  output logic                           out_reflection_on,
  input  logic                           cfg_we,
  input  logic [bpl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  bpl_pkg::cfg_t        cfg_r;
  logic                 s1_vld_r;
  bpl_pkg::opcode_t     s1_op_r;
  logic [5:0]           s1_pix_r;
  logic [7:0]           s1_rnd_r;
  logic                 out_vld_r;
  logic [7:0]           level_r;
  logic [7:0]           hue_r;
  logic                 refl_r;

  logic                 out_load;
  logic                 s1_adv;
  logic                 tick_en;
  logic                 pix_ok;
  logic [7:0]           lvl_main;
  logic [7:0]           lvl_mirror;
  logic [7:0]           level_nxt;
  bpl_pkg::anim_state_t st;
  bpl_pkg::anim_state_t st_nxt;

  assign out_load = !out_vld_r || out_ready;
  assign s1_adv   = s1_vld_r && out_load;
  assign in_ready = !s1_vld_r || out_load;
  assign tick_en  = s1_adv && (s1_op_r == bpl_pkg::OP_TICK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness   <= 8'd0;
      cfg_r.step_size    <= 8'd8;
      cfg_r.hue_divider  <= 7'd3;
      cfg_r.hue_limit    <= 9'd256;
      cfg_r.split_enable <= 1'b1;
    end else if (cfg_we) begin
      case (bpl_pkg::cfg_idx_t'(cfg_index))
        bpl_pkg::REG_BRIGHTNESS:   cfg_r.brightness   <= cfg_wdata[7:0];
        bpl_pkg::REG_STEP_SIZE:    cfg_r.step_size    <= cfg_wdata[7:0];
        bpl_pkg::REG_HUE_DIVIDER:  cfg_r.hue_divider  <= cfg_wdata[6:0];
        bpl_pkg::REG_HUE_LIMIT:    cfg_r.hue_limit    <= cfg_wdata[8:0];
        bpl_pkg::REG_SPLIT_ENABLE: cfg_r.split_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  bpl_anim u_anim (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .tick_en (tick_en),
    .rnd     (s1_rnd_r),
    .st      (st),
    .st_nxt  (st_nxt)
  );

  bpl_pulse u_pulse_main (
    .pos         (st.main_pos),
    .pixel_index (s1_pix_r),
    .brightness  (cfg_r.brightness),
    .level       (lvl_main)
  );

  bpl_pulse u_pulse_mirror (
    .pos         (st.mirror_pos),
    .pixel_index (s1_pix_r),
    .brightness  (cfg_r.brightness),
    .level       (lvl_mirror)
  );

  always_comb begin
    pix_ok    = (32'(s1_pix_r) < 32'(bpl_pkg::PIXEL_COUNT));
    level_nxt = 8'h00;
    if (s1_op_r == bpl_pkg::OP_PIXEL && pix_ok) begin
      level_nxt = lvl_main;
      if (st.mirror_act && (lvl_mirror > lvl_main)) begin
        level_nxt = lvl_mirror;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (out_load) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r  <= bpl_pkg::opcode_t'(in_opcode);
      s1_pix_r <= in_pixel_index;
      s1_rnd_r <= in_random_byte;
    end
    if (s1_adv) begin
      level_r <= level_nxt;
      hue_r   <= st_nxt.hue;
      refl_r  <= st_nxt.mirror_act;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_pixel_level   = level_r;
  assign out_hue           = hue_r;
  assign out_reflection_on = refl_r;

  // A tick transfer always reports a zero pixel level.
  a_tick_level_zero: assert property (@(posedge clk) disable iff (!rst_n)
    tick_en |=> (out_pixel_level == 8'h00))
    else $error("tick result carries a nonzero pixel level");

  // Pixel reads never disturb the animation state.
  a_pixel_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_op_r == bpl_pkg::OP_PIXEL) |=> $stable(st))
    else $error("pixel read changed the animation state");

  // Both pulse positions stay on the ring.
  a_pos_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(st.main_pos) < 32'(bpl_pkg::RING_SPAN)) &&
    (32'(st.mirror_pos) < 32'(bpl_pkg::RING_SPAN)))
    else $error("pulse position left the ring");

  // The input side only stalls when both stages are full and the result is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_vld_r && out_vld_r && !out_ready))
    else $error("input stalled without a held result");

endmodule

// ===== bench/bpl_render_checker.sv =====
// Checker that predicts and compares every result of the bouncing pulse LED renderer.
`timescale 1ns / 100ps

module bpl_render_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_opcode,
  input  logic [5:0]                     in_pixel_index,
  input  logic [7:0]                     in_random_byte,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [7:0]                     out_pixel_level,
  input  logic [7:0]                     out_hue,
  input  logic                           out_reflection_on,
  input  logic                           cfg_we,
  input  logic [bpl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             backlog
);

  typedef struct packed {
    logic [7:0] level;
    logic [7:0] hue;
    logic       reflect;
  } led_result_t;

  bpl_pkg::cfg_t        settings;
  bpl_pkg::anim_state_t ring;
  led_result_t          awaited_leds[$];

  // Level that one pulse gives a pixel, measured the short way round the ring.
  function automatic logic [7:0] pulse_glow(logic [bpl_pkg::POS_W-1:0] pos,
                                            logic [5:0] pixel);
    longint spot;
    longint gap;
    longint fall;
    spot = longint'(pixel) << 8;
    gap = (spot >= longint'(pos)) ? spot - longint'(pos) : longint'(pos) - spot;
    if (gap > bpl_pkg::RING_SPAN - gap) gap = bpl_pkg::RING_SPAN - gap;
    fall = (gap * gap) >> bpl_pkg::FALL_SHIFT;
    if (fall > longint'(settings.brightness)) return 8'd0;
    return settings.brightness - fall[7:0];
  endfunction

  function automatic logic [7:0] next_hue(logic [7:0] hue);
    logic [8:0] bumped;
    bumped = {1'b0, hue} + 9'd1;
    if (bumped >= settings.hue_limit) bumped = '0;
    return bumped[7:0];
  endfunction

  function automatic logic [bpl_pkg::POS_W-1:0] ring_shift(logic [bpl_pkg::POS_W-1:0] pos,
                                                           logic [7:0] stride,
                                                           logic ahead);
    int moved;
    if (ahead) moved = (int'(pos) + int'(stride)) % bpl_pkg::RING_SPAN;
    else moved = (int'(pos) + bpl_pkg::RING_SPAN - int'(stride) % bpl_pkg::RING_SPAN)
                 % bpl_pkg::RING_SPAN;
    return moved[bpl_pkg::POS_W-1:0];
  endfunction

  always @(posedge clk) begin
    led_result_t got;
    led_result_t want;
    logic [7:0]  glow;
    logic [7:0]  echo_glow;
    if (!rst_n) begin
      settings = '{brightness: 8'd0, step_size: 8'd8, hue_divider: 7'd3, hue_limit: 9'd256,
                   split_enable: 1'b1};
      ring = '{main_pos: '0, mirror_pos: bpl_pkg::MIRROR_RESET, mirror_act: 1'b1,
               backward: 1'b0, hue: 8'd0, hue_cnt: 7'd3};
      awaited_leds.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (bpl_pkg::cfg_idx_t'(cfg_index))
          bpl_pkg::REG_BRIGHTNESS:   settings.brightness = cfg_wdata[7:0];
          bpl_pkg::REG_STEP_SIZE:    settings.step_size = cfg_wdata[7:0];
          bpl_pkg::REG_HUE_DIVIDER:  settings.hue_divider = cfg_wdata[6:0];
          bpl_pkg::REG_HUE_LIMIT:    settings.hue_limit = cfg_wdata[8:0];
          bpl_pkg::REG_SPLIT_ENABLE: settings.split_enable = cfg_wdata[0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        glow = 8'd0;
        if (bpl_pkg::opcode_t'(in_opcode) == bpl_pkg::OP_TICK) begin
          if (settings.split_enable) begin
            if (ring.hue_cnt <= 7'd1) begin
              ring.hue_cnt = settings.hue_divider;
              ring.hue = next_hue(ring.hue);
            end else begin
              ring.hue_cnt = ring.hue_cnt - 7'd1;
            end
            // A reflection is spawned only when none is active; an active one is
            // removed where it meets the main pulse.
            if (!ring.mirror_act) begin
              if (in_random_byte == bpl_pkg::SPAWN_CODE) begin
                ring.mirror_act = 1'b1;
                ring.mirror_pos = ring.main_pos;
              end
            end else if (ring.main_pos == ring.mirror_pos) begin
              ring.mirror_act = 1'b0;
              if (in_random_byte[1:0] == bpl_pkg::REVERSE_CODE) ring.backward = !ring.backward;
            end
          end else begin
            ring.hue = next_hue(ring.hue);
          end
          ring.main_pos = ring_shift(ring.main_pos, settings.step_size, !ring.backward);
          ring.mirror_pos = ring_shift(ring.mirror_pos, settings.step_size, ring.backward);
        end else if (int'(in_pixel_index) < bpl_pkg::PIXEL_COUNT) begin
          glow = pulse_glow(ring.main_pos, in_pixel_index);
          if (ring.mirror_act) begin
            echo_glow = pulse_glow(ring.mirror_pos, in_pixel_index);
            if (echo_glow > glow) glow = echo_glow;
          end
        end
        awaited_leds.push_back('{level: glow, hue: ring.hue, reflect: ring.mirror_act});
      end

      if (out_valid && out_ready) begin
        got = '{level: out_pixel_level, hue: out_hue, reflect: out_reflection_on};
        if (awaited_leds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: unexpected result: level %0d hue %0d reflection %0b",
                     $realtime, got.level, got.hue, got.reflect);
        end else begin
          want = awaited_leds.pop_front();
          if (got.level != want.level || got.hue != want.hue || got.reflect != want.reflect) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%t: expected lvl %0d hue %0d refl %0b, got lvl %0d hue %0d refl %0b",
                       $realtime, want.level, want.hue, want.reflect,
                       got.level, got.hue, got.reflect);
          end
        end
      end
    end
    backlog = awaited_leds.size();
  end

endmodule

// ===== bench/bouncing_pulse_led_renderer_tb.sv =====
// Testbench top for the bouncing pulse LED renderer: stimulus, idling and the verdict.
`timescale 1ns / 100ps

module bouncing_pulse_led_renderer_tb;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 80;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic                           in_opcode;
  logic [5:0]                     in_pixel_index;
  logic [7:0]                     in_random_byte;
  logic                           out_valid;
  logic                           out_ready;
  logic [7:0]                     out_pixel_level;
  logic [7:0]                     out_hue;
  logic                           out_reflection_on;
  logic                           cfg_we;
  logic [bpl_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [bpl_pkg::CFG_DATA_W-1:0] cfg_wdata;

  int   mismatches;
  int   backlog;
  int   idle_odds;
  logic long_hold;

  bouncing_pulse_led_renderer u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_pixel_index    (in_pixel_index),
    .in_random_byte    (in_random_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_level   (out_pixel_level),
    .out_hue           (out_hue),
    .out_reflection_on (out_reflection_on),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  bpl_render_checker u_render_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_pixel_index    (in_pixel_index),
    .in_random_byte    (in_random_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_level   (out_pixel_level),
    .out_hue           (out_hue),
    .out_reflection_on (out_reflection_on),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .mismatches        (mismatches),
    .backlog           (backlog)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Offers one item and holds it until the transfer; may then leave a random gap.
  task automatic offer(bpl_pkg::opcode_t op, logic [5:0] pixel, logic [7:0] rnd);
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_pixel_index <= pixel;
    in_random_byte <= rnd;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  // Stops offering and waits until every expected result has come out.
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (backlog != 0);
  endtask

  task automatic load_settings(logic [7:0] glow, logic [7:0] stride, logic [6:0] divide,
                               logic [8:0] wrap, logic split);
    cfg_we    <= 1'b1;
    cfg_index <= bpl_pkg::REG_BRIGHTNESS;
    cfg_wdata <= {1'b0, glow};
    @(negedge clk);
    cfg_index <= bpl_pkg::REG_STEP_SIZE;
    cfg_wdata <= {1'b0, stride};
    @(negedge clk);
    cfg_index <= bpl_pkg::REG_HUE_DIVIDER;
    cfg_wdata <= {2'b00, divide};
    @(negedge clk);
    cfg_index <= bpl_pkg::REG_HUE_LIMIT;
    cfg_wdata <= wrap;
    @(negedge clk);
    cfg_index <= bpl_pkg::REG_SPLIT_ENABLE;
    cfg_wdata <= {8'd0, split};
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off counted here.
  initial begin
    int stall_left;
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold && stall_left == 0) begin
        stall_left = LONG_HOLD;
        long_hold <= 1'b0;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Ends the run when no transfer of any kind happens for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int         random_sent;
    int         episode;
    int         span;
    logic [7:0] glow;
    logic [7:0] stride;
    logic [6:0] divide;
    logic [8:0] wrap;
    logic       split;
    logic [5:0] pick_pixel;
    logic [7:0] pick_rnd;

    in_valid       = 1'b0;
    in_opcode      = bpl_pkg::OP_TICK;
    in_pixel_index = '0;
    in_random_byte = '0;
    cfg_we         = 1'b0;
    cfg_index      = bpl_pkg::REG_BRIGHTNESS;
    cfg_wdata      = '0;
    idle_odds      = 0;
    long_hold      = 1'b0;
    rst_n          = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Default registers: zero brightness reads pixel 0 as dark.
    offer(bpl_pkg::OP_PIXEL, 6'd0, 8'h00);
    settle();

    // Full brightness, still pulses: peaks, wrap-around offset, floor at zero.
    load_settings(8'd255, 8'd0, 7'd1, 9'd256, 1'b1);
    offer(bpl_pkg::OP_PIXEL, 6'd0, 8'h00);
    offer(bpl_pkg::OP_PIXEL, 6'd32, 8'hFF);
    offer(bpl_pkg::OP_PIXEL, 6'd63, 8'h00);
    offer(bpl_pkg::OP_PIXEL, 6'd1, 8'h00);
    offer(bpl_pkg::OP_PIXEL, 6'd16, 8'h00);
    offer(bpl_pkg::OP_PIXEL, 6'd48, 8'h00);
    offer(bpl_pkg::OP_TICK, 6'd63, 8'hFF);
    settle();

    // Divider of zero and a hue limit of zero.
    load_settings(8'd200, 8'd255, 7'd0, 9'd0, 1'b1);
    offer(bpl_pkg::OP_TICK, 6'd0, 8'h03);
    offer(bpl_pkg::OP_TICK, 6'd0, 8'h00);
    offer(bpl_pkg::OP_PIXEL, 6'd0, 8'h00);
    offer(bpl_pkg::OP_PIXEL, 6'd63, 8'h00);
    settle();

    // Plain mode with a hue limit past the 8-bit range; spawn code is ignored.
    load_settings(8'd128, 8'd128, 7'd127, 9'd511, 1'b0);
    offer(bpl_pkg::OP_TICK, 6'd0, 8'hFF);
    offer(bpl_pkg::OP_TICK, 6'd0, 8'hFF);
    offer(bpl_pkg::OP_TICK, 6'd0, 8'hFF);
    offer(bpl_pkg::OP_PIXEL, 6'd10, 8'h00);
    offer(bpl_pkg::OP_PIXEL, 6'd31, 8'h00);
    settle();

    load_settings(8'd1, 8'd1, 7'd2, 9'd1, 1'b1);
    offer(bpl_pkg::OP_TICK, 6'd0, 8'h00);
    offer(bpl_pkg::OP_PIXEL, 6'd5, 8'h00);
    offer(bpl_pkg::OP_TICK, 6'd0, 8'hFF);

    random_sent = 0;
    episode     = 0;
    while (random_sent < 1050) begin
      settle();
      case ($urandom_range(0, 3))
        0:       glow = 8'd0;
        1, 2:    glow = 8'd255;
        default: glow = 8'($urandom_range(1, 254));
      endcase
      // A still pulse meets its own fresh reflection at once, so zero steps
      // exercise spawning and removal; half-pixel steps close the gap in time.
      case ($urandom_range(0, 6))
        0, 1:    stride = 8'd0;
        2, 3:    stride = 8'd128;
        4:       stride = 8'd255;
        5:       stride = 8'd64;
        default: stride = 8'($urandom_range(1, 254));
      endcase
      case ($urandom_range(0, 4))
        0:       divide = 7'd0;
        1:       divide = 7'd1;
        2:       divide = 7'd127;
        default: divide = 7'($urandom_range(1, 127));
      endcase
      case ($urandom_range(0, 6))
        0, 1:    wrap = 9'd256;
        2:       wrap = 9'd511;
        3:       wrap = 9'd0;
        4:       wrap = 9'd1;
        5:       wrap = 9'($urandom_range(257, 510));
        default: wrap = 9'($urandom_range(2, 255));
      endcase
      split = ($urandom_range(0, 4) != 0);

      span = $urandom_range(30, 80);
      if (episode == 3) begin
        // The receiver holds off while items keep coming, so the block fills up.
        idle_odds <= 0;
        long_hold <= 1'b1;
        span = 100;
      end else if (random_sent >= 880) begin
        idle_odds <= 0;
      end else begin
        case ($urandom_range(0, 2))
          0:       idle_odds <= 0;
          1:       idle_odds <= 3;
          default: idle_odds <= 8;
        endcase
      end
      load_settings(glow, stride, divide, wrap, split);

      repeat (span) begin
        pick_pixel = 6'($urandom_range(0, 63));
        pick_rnd   = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 55) begin
          if ($urandom_range(0, 3) == 0) pick_rnd = bpl_pkg::SPAWN_CODE;
          offer(bpl_pkg::OP_TICK, pick_pixel, pick_rnd);
        end else begin
          offer(bpl_pkg::OP_PIXEL, pick_pixel, pick_rnd);
        end
        random_sent++;
      end
      episode++;
    end

    settle();
    repeat (6) @(negedge clk);
    if (mismatches == 0 && backlog == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/bpl_pkg.sv
hdl/bpl_pulse.sv
hdl/bpl_anim.sv
hdl/bouncing_pulse_led_renderer.sv
bench/bpl_render_checker.sv
bench/bouncing_pulse_led_renderer_tb.sv
